/* hw/rtl/ptok_pkg.sv */
// Package: shared types, constants and helper functions of the tokeniser.
`default_nettype none
package ptok_pkg;

    // Largest source the block is sized for; offsets saturate below it.
    localparam int MAX_SOURCE = 65536;
    localparam logic [15:0] POS_CAP =
        ((MAX_SOURCE - 1) > 65535) ? 16'hFFFF : 16'(MAX_SOURCE - 1);
    localparam logic [15:0] LINE_CAP = 16'hFFFF;

    // Token queue sizing: one item can raise at most three tokens.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 3;
    localparam int PUSH_CW    = $clog2(MAX_PUSH + 1);

    // Item codes.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Token kinds.
    localparam logic [2:0] K_WORD  = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_IN    = 3'd3;
    localparam logic [2:0] K_NOTIN = 3'd4;
    localparam logic [2:0] K_CMP   = 3'd5;
    localparam logic [2:0] K_SYM   = 3'd6;
    localparam logic [2:0] K_END   = 3'd7;

    // Byte values the lexer looks for.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] UTF_LEAD  = 8'hE2;
    localparam logic [7:0] UTF_MID   = 8'h88;
    localparam logic [7:0] UTF_NOTIN = 8'h89;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_WORD    = 4'd1,
        M_NUM     = 4'd2,
        M_NUMSEP  = 4'd3,
        M_STR     = 4'd4,
        M_COMMENT = 4'd5,
        M_DASH    = 4'd6,
        M_LTGT    = 4'd7,
        M_UTF1    = 4'd8,
        M_UTF2    = 4'd9
    } t_mode;

    typedef struct packed {
        logic       func;
        logic [7:0] source_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic        last_of_run;
    } t_token;

    // Tokens raised by one item, oldest in slot 0.
    typedef struct packed {
        logic [PUSH_CW-1:0]      count;
        t_token [MAX_PUSH-1:0]   tok;
    } t_push;

    function automatic logic [15:0] sat_inc(input logic [15:0] x);
        return (x < POS_CAP) ? x + 16'd1 : x;
    endfunction

    function automatic logic [15:0] span(input logic [15:0] from, input logic [15:0] to);
        return (to >= from) ? to - from : 16'd0;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_UNDER) || (c == CH_APOS);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ptok_lexer.sv */
// Lexer core: mode register, offsets and line counter, and token formation.
`default_nettype none
module ptok_lexer import ptok_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s1_valid,
    input  wire t_item i_s1,
    output t_push      o_push
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_tb,   n_tb;
    logic [15:0] r_pos,  n_pos;
    logic [15:0] r_line, n_line;
    logic [15:0] r_hp0,  n_hp0;
    logic [15:0] r_hp1,  n_hp1;
    logic        r_at,   n_at;

    logic [7:0]  c;
    logic [15:0] p;
    logic        w_end, w_byte, w_fall, w_sym, w_close;

    assign c       = i_s1.source_byte;
    assign p       = r_pos;
    assign w_end   = i_s1_valid && (i_s1.func == FUNC_END);
    assign w_byte  = i_s1_valid && (i_s1.func == FUNC_BYTE);
    assign w_close = (c == CH_RPAREN) || (c == CH_RBRACK);
    // Byte that, lexed from idle, is a one-byte symbol on its own.
    assign w_sym   = !is_space(c) && (c != CH_DASH) && (c != UTF_LEAD) && !is_word(c) &&
                     (c != CH_QUOTE) && (c != CH_LT) && (c != CH_GT);

    // Does the current mode give the byte back to be lexed from idle?
    always_comb begin
        unique case (r_mode)
            M_WORD:    w_fall = !is_word(c);
            M_NUM:     w_fall = !is_digit(c) && (c != CH_DOT) && (c != CH_SLASH);
            M_NUMSEP:  w_fall = !is_digit(c);
            M_STR:     w_fall = 1'b0;
            M_COMMENT: w_fall = (c == CH_NL);
            M_DASH:    w_fall = (c != CH_DASH) && !(is_digit(c) && !r_at);
            M_LTGT:    w_fall = (c != CH_EQ);
            M_UTF1:    w_fall = (c != UTF_MID);
            M_UTF2:    w_fall = (c != UTF_MID) && (c != UTF_NOTIN);
            default:   w_fall = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        n_mode = r_mode;
        n_tb   = r_tb;
        n_pos  = r_pos;
        n_line = r_line;
        n_hp0  = r_hp0;
        n_hp1  = r_hp1;
        n_at   = r_at;
        if (w_end) begin
            n_mode = M_IDLE;
            n_tb   = '0;
            n_pos  = '0;
            n_line = 16'd1;
            n_hp0  = '0;
            n_hp1  = '0;
            n_at   = 1'b0;
        end else if (w_byte) begin
            n_pos = sat_inc(p);
            // Term flag left by the tokens the mode itself closes.
            unique case (r_mode)
                M_WORD, M_NUM: if (w_fall) n_at = 1'b1;
                M_NUMSEP, M_DASH, M_UTF1: if (w_fall) n_at = 1'b0;
                M_STR:    if (c == CH_QUOTE) n_at = 1'b0;
                M_LTGT:   n_at = 1'b0;
                M_UTF2:   n_at = !w_fall;
                default:  ;
            endcase
            if (w_fall) begin
                n_mode = M_IDLE;
                if (c == CH_NL) begin
                    if (r_line < LINE_CAP) n_line = r_line + 16'd1;
                end else if (is_space(c)) begin
                end else if (c == CH_DASH) begin
                    n_mode = M_DASH;
                    n_tb   = p;
                end else if (c == UTF_LEAD) begin
                    n_mode = M_UTF1;
                    n_hp0  = p;
                    n_tb   = p;
                end else if (is_digit(c)) begin
                    n_mode = M_NUM;
                    n_tb   = p;
                end else if (c == CH_QUOTE) begin
                    n_mode = M_STR;
                    n_tb   = sat_inc(p);
                end else if (is_word(c)) begin
                    n_mode = M_WORD;
                    n_tb   = p;
                end else if ((c == CH_LT) || (c == CH_GT)) begin
                    n_mode = M_LTGT;
                    n_tb   = p;
                end else begin
                    n_at = w_close;
                end
            end else begin
                unique case (r_mode)
                    M_NUM: begin
                        if (!is_digit(c)) begin
                            n_mode = M_NUMSEP;
                            n_hp0  = p;
                        end
                    end
                    M_NUMSEP:  n_mode = M_NUM;
                    M_STR:     if (c == CH_QUOTE) n_mode = M_IDLE;
                    M_DASH:    n_mode = (c == CH_DASH) ? M_COMMENT : M_NUM;
                    M_LTGT:    n_mode = M_IDLE;
                    M_UTF1: begin
                        n_mode = M_UTF2;
                        n_hp1  = p;
                    end
                    M_UTF2:    n_mode = M_IDLE;
                    default:   ;
                endcase
            end
        end
    end

    // Tokens raised by the item in the input register.
    always_comb begin
        t_token [MAX_PUSH-1:0] toks;
        logic [PUSH_CW-1:0]    cnt;
        toks = '0;
        cnt  = '0;
        for (int k = 0; k < MAX_PUSH; k++) toks[k].token_line = r_line;
        if (w_end) begin
            unique case (r_mode)
                M_WORD, M_NUM, M_STR: begin
                    toks[cnt].token_kind   = (r_mode == M_WORD) ? K_WORD :
                                             (r_mode == M_NUM) ? K_NUM : K_STR;
                    toks[cnt].token_start  = r_tb;
                    toks[cnt].token_length = span(r_tb, p);
                    cnt = cnt + 1'b1;
                end
                M_NUMSEP: begin
                    toks[cnt].token_kind   = K_NUM;
                    toks[cnt].token_start  = r_tb;
                    toks[cnt].token_length = span(r_tb, r_hp0);
                    cnt = cnt + 1'b1;
                    toks[cnt].token_kind   = K_SYM;
                    toks[cnt].token_start  = r_hp0;
                    toks[cnt].token_length = 16'd1;
                    cnt = cnt + 1'b1;
                end
                M_DASH, M_LTGT: begin
                    toks[cnt].token_kind   = K_SYM;
                    toks[cnt].token_start  = r_tb;
                    toks[cnt].token_length = 16'd1;
                    cnt = cnt + 1'b1;
                end
                M_UTF1, M_UTF2: begin
                    toks[cnt].token_kind   = K_SYM;
                    toks[cnt].token_start  = r_hp0;
                    toks[cnt].token_length = 16'd1;
                    cnt = cnt + 1'b1;
                    if (r_mode == M_UTF2) begin
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_hp1;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                    end
                end
                default: ;
            endcase
            toks[cnt].token_kind   = K_END;
            toks[cnt].token_start  = p;
            toks[cnt].token_length = 16'd0;
            cnt = cnt + 1'b1;
        end else if (w_byte) begin
            unique case (r_mode)
                M_WORD, M_NUM: begin
                    if (w_fall) begin
                        toks[cnt].token_kind   = (r_mode == M_WORD) ? K_WORD : K_NUM;
                        toks[cnt].token_start  = r_tb;
                        toks[cnt].token_length = span(r_tb, p);
                        cnt = cnt + 1'b1;
                    end
                end
                M_NUMSEP: begin
                    if (w_fall) begin
                        toks[cnt].token_kind   = K_NUM;
                        toks[cnt].token_start  = r_tb;
                        toks[cnt].token_length = span(r_tb, r_hp0);
                        cnt = cnt + 1'b1;
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_hp0;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        toks[cnt].token_kind   = K_STR;
                        toks[cnt].token_start  = r_tb;
                        toks[cnt].token_length = span(r_tb, p);
                        cnt = cnt + 1'b1;
                    end
                end
                M_DASH: begin
                    if (w_fall) begin
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_tb;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                    end
                end
                M_LTGT: begin
                    toks[cnt].token_kind   = w_fall ? K_SYM : K_CMP;
                    toks[cnt].token_start  = r_tb;
                    toks[cnt].token_length = w_fall ? 16'd1 : 16'd2;
                    cnt = cnt + 1'b1;
                end
                M_UTF1: begin
                    if (w_fall) begin
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_hp0;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                    end
                end
                M_UTF2: begin
                    if (w_fall) begin
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_hp0;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                        toks[cnt].token_kind   = K_SYM;
                        toks[cnt].token_start  = r_hp1;
                        toks[cnt].token_length = 16'd1;
                        cnt = cnt + 1'b1;
                    end else begin
                        toks[cnt].token_kind   = (c == UTF_MID) ? K_IN : K_NOTIN;
                        toks[cnt].token_start  = r_tb;
                        toks[cnt].token_length = 16'd3;
                        cnt = cnt + 1'b1;
                    end
                end
                default: ;
            endcase
            if (w_fall && w_sym) begin
                toks[cnt].token_kind   = K_SYM;
                toks[cnt].token_start  = p;
                toks[cnt].token_length = 16'd1;
                cnt = cnt + 1'b1;
            end
        end
        for (int k = 0; k < MAX_PUSH; k++) begin
            toks[k].last_of_run = (PUSH_CW'(k + 1) == cnt);
        end
        o_push.count = cnt;
        o_push.tok   = toks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_tb   <= '0;
            r_pos  <= '0;
            r_line <= 16'd1;
            r_hp0  <= '0;
            r_hp1  <= '0;
            r_at   <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_tb   <= n_tb;
            r_pos  <= n_pos;
            r_line <= n_line;
            r_hp0  <= n_hp0;
            r_hp1  <= n_hp1;
            r_at   <= n_at;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ptok_fifo.sv */
// Token queue: takes up to three tokens a cycle, hands out one a cycle unless stalled.
`default_nettype none
module ptok_fifo import ptok_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_push         i_push,
    output logic               o_valid,
    input  wire logic          i_stall,
    output t_token             o_token,
    output logic [FIFO_CW-1:0] o_fill
);

    t_token               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, n_wp;
    logic [FIFO_AW-1:0]   r_rp, n_rp;
    logic [FIFO_CW-1:0]   r_fill, n_fill;
    logic                 w_pop;

    assign o_valid = (r_fill != '0);
    assign o_token = r_mem[r_rp];
    assign o_fill  = r_fill;
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_wp   = r_wp + FIFO_AW'(i_push.count);
        n_rp   = r_rp + FIFO_AW'(w_pop);
        n_fill = r_fill + FIFO_CW'(i_push.count) - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (PUSH_CW'(k) < i_push.count) begin
                r_mem[r_wp + FIFO_AW'(k)] <= i_push.tok[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/proof_language_tokenizer_unit.sv */
// Top level of the proof-language tokeniser: input register, lexer core and token queue.
//
//   Channel   Direction  Handshake              Payload
//   input     in         i_valid / o_stall      i_item  (t_item:  func, source_byte)
//   output    out        o_valid / i_stall      o_token (t_token: kind, start, length,
//                                                        line, last_of_run)
//
// One source byte is taken per cycle while o_stall is low. A transaction first
// lands in the input register; in the following cycle the lexer core updates
// its mode and counters and writes the tokens it raises (none to three) into
// the token queue, whose head drives the output. The output channel hands out
// one token per cycle while i_stall is low, so when items raise more than one
// token each on average the queue fills and the input is held back until the
// sink catches up; with a sink that never stalls, a three-token item stalls
// the input and shorter runs do not.
// Reset is synchronous and active low; it empties the queue and returns the
// lexer to idle at offset zero on line one. An end transaction returns the
// lexer to idle in the same way once its tokens are queued. o_stall rises only
// while the queue lacks room for the worst case of the held item plus a new
// one; a stalled output never loses or repeats a token.
`default_nettype none
module proof_language_tokenizer_unit import ptok_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_item  i_item,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_token      o_token
);

    logic               r_s1_valid;
    t_item              r_s1;
    t_push              w_push;
    logic [FIFO_CW-1:0] w_fill;
    logic               w_accept;

    // Room is reserved for the held transaction and for the one being taken.
    assign o_stall  = (32'(w_fill) + (r_s1_valid ? 32'(MAX_PUSH) : 32'd0) + 32'(MAX_PUSH))
                      > 32'(FIFO_DEPTH);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= i_item;
        end
    end

    ptok_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .o_push     (w_push)
    );

    ptok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (o_token),
        .o_fill  (w_fill)
    );

    // The queue never overflows.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_fill) <= 32'(FIFO_DEPTH))
        else $error("token queue over capacity");

    // A taken transaction sits in the input register in the next cycle.
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted transaction not registered");

    // An end transaction always raises at least its end token.
    a_end_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1.func == FUNC_END)) |-> (w_push.count != '0))
        else $error("end transaction raised no token");

    // Nothing is queued without a transaction in the input register.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> (w_push.count == '0))
        else $error("token raised without a transaction");

endmodule
`default_nettype wire

/* verif/tb_proof_language_tokenizer_unit.sv */
// Self-checking testbench for the proof-language tokeniser, with its own token predictor.
`timescale 1ns / 100ps
module tb_proof_language_tokenizer_unit import ptok_pkg::*; ();

    // The run is cut short here.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // The output lags the input only by the input register and the token queue, so a short settle suffices.
    localparam int DRAIN_CYCLES = 20;

    // Keeps its own copy of the lexer state and predicts the tokens that each accepted
    // transaction raises. Tokens still owed by the block wait in arrival order.
    class token_scoreboard;
        t_mode       lex_mode;
        logic [15:0] held_pos [2];
        logic [15:0] token_begin;
        logic [15:0] byte_position;
        logic [15:0] line_count;
        bit          after_term;
        t_token      fresh [$];
        t_token      pending_tokens [$];
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            lex_mode      = M_IDLE;
            held_pos[0]   = '0;
            held_pos[1]   = '0;
            token_begin   = '0;
            byte_position = '0;
            line_count    = 16'd1;
            after_term    = 1'b0;
        endfunction

        function logic [15:0] bump(logic [15:0] x);
            return (x < POS_CAP) ? x + 16'd1 : x;
        endfunction

        // Distance between two saturated offsets; a backwards distance reads as zero.
        function logic [15:0] gap(logic [15:0] from, logic [15:0] upto);
            return (upto >= from) ? upto - from : 16'd0;
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit word_char(logic [7:0] c);
            return numeral(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)
                || c == CH_UNDER || c == CH_APOS;
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void emit(logic [2:0] kind, logic [15:0] start, logic [15:0] len, bit term);
            t_token t;
            t.token_kind   = kind;
            t.token_start  = start;
            t.token_length = len;
            t.token_line   = line_count;
            t.last_of_run  = 1'b0;
            fresh = {fresh, t};
            if (kind != K_END) after_term = term;
        endfunction

        // A byte seen between tokens: skip it, count a line, open a token or emit a symbol.
        function void start_token(logic [7:0] c, logic [15:0] p);
            lex_mode = M_IDLE;
            if (c == CH_NL) begin
                if (line_count < LINE_CAP) line_count = line_count + 16'd1;
                return;
            end
            if (blank_char(c)) return;
            if (c == CH_DASH) begin
                lex_mode    = M_DASH;
                token_begin = p;
            end else if (c == UTF_LEAD) begin
                lex_mode    = M_UTF1;
                held_pos[0] = p;
                token_begin = p;
            end else if (numeral(c)) begin
                lex_mode    = M_NUM;
                token_begin = p;
            end else if (c == CH_QUOTE) begin
                lex_mode    = M_STR;
                token_begin = bump(p);
            end else if (word_char(c)) begin
                lex_mode    = M_WORD;
                token_begin = p;
            end else if (c == CH_LT || c == CH_GT) begin
                lex_mode    = M_LTGT;
                token_begin = p;
            end else begin
                emit(K_SYM, p, 16'd1, c == CH_RPAREN || c == CH_RBRACK);
            end
        endfunction

        // Continues or closes the open token; a closing byte is then lexed afresh.
        function void lex_byte(logic [7:0] c, logic [15:0] p);
            case (lex_mode)
                M_WORD: begin
                    if (word_char(c)) return;
                    emit(K_WORD, token_begin, gap(token_begin, p), 1'b1);
                end
                M_NUM: begin
                    if (numeral(c)) return;
                    if (c == CH_DOT || c == CH_SLASH) begin
                        lex_mode    = M_NUMSEP;
                        held_pos[0] = p;
                        return;
                    end
                    emit(K_NUM, token_begin, gap(token_begin, p), 1'b1);
                end
                M_NUMSEP: begin
                    if (numeral(c)) begin
                        lex_mode = M_NUM;
                        return;
                    end
                    emit(K_NUM, token_begin, gap(token_begin, held_pos[0]), 1'b1);
                    emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        emit(K_STR, token_begin, gap(token_begin, p), 1'b0);
                        lex_mode = M_IDLE;
                    end
                    return;
                end
                M_COMMENT: begin
                    if (c != CH_NL) return;
                end
                M_DASH: begin
                    if (c == CH_DASH) begin
                        lex_mode = M_COMMENT;
                        return;
                    end
                    if (numeral(c) && !after_term) begin
                        lex_mode = M_NUM;
                        return;
                    end
                    emit(K_SYM, token_begin, 16'd1, 1'b0);
                end
                M_LTGT: begin
                    if (c == CH_EQ) begin
                        emit(K_CMP, token_begin, 16'd2, 1'b0);
                        lex_mode = M_IDLE;
                        return;
                    end
                    emit(K_SYM, token_begin, 16'd1, 1'b0);
                end
                M_UTF1: begin
                    if (c == UTF_MID) begin
                        held_pos[1] = p;
                        lex_mode    = M_UTF2;
                        return;
                    end
                    emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                end
                M_UTF2: begin
                    if (c == UTF_MID || c == UTF_NOTIN) begin
                        emit((c == UTF_MID) ? K_IN : K_NOTIN, token_begin, 16'd3, 1'b1);
                        lex_mode = M_IDLE;
                        return;
                    end
                    emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                    emit(K_SYM, held_pos[1], 16'd1, 1'b0);
                end
                default: ;
            endcase
            start_token(c, p);
        endfunction

        // End of source: whatever is open is flushed, then the end token follows.
        function void close_source();
            logic [15:0] p;
            p = byte_position;
            case (lex_mode)
                M_WORD: emit(K_WORD, token_begin, gap(token_begin, p), 1'b1);
                M_NUM:  emit(K_NUM, token_begin, gap(token_begin, p), 1'b1);
                M_NUMSEP: begin
                    emit(K_NUM, token_begin, gap(token_begin, held_pos[0]), 1'b1);
                    emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                end
                M_STR:  emit(K_STR, token_begin, gap(token_begin, p), 1'b0);
                M_DASH, M_LTGT: emit(K_SYM, token_begin, 16'd1, 1'b0);
                M_UTF1: emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                M_UTF2: begin
                    emit(K_SYM, held_pos[0], 16'd1, 1'b0);
                    emit(K_SYM, held_pos[1], 16'd1, 1'b0);
                end
                default: ;
            endcase
            emit(K_END, p, 16'd0, 1'b0);
        endfunction

        function void note_item(t_item it);
            logic [15:0] p;
            fresh.delete();
            if (it.func == FUNC_END) begin
                close_source();
                clear();
            end else begin
                p = byte_position;
                lex_byte(it.source_byte, p);
                byte_position = bump(p);
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
            pending_tokens = {pending_tokens, fresh};
        endfunction

        function void report(string what, t_token want, t_token got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected kind %0d start %0d len %0d line %0d last %0d, ",
                         what, want.token_kind, want.token_start, want.token_length,
                         want.token_line, want.last_of_run,
                         "got kind %0d start %0d len %0d line %0d last %0d",
                         got.token_kind, got.token_start, got.token_length,
                         got.token_line, got.last_of_run);
        endfunction

        function void check_token(t_token got);
            t_token want;
            string  bad;
            if (pending_tokens.size() == 0) begin
                report("no token was owed", '0, got);
                return;
            end
            want = pending_tokens.pop_front();
            bad  = "";
            if (got.token_kind   !== want.token_kind)   bad = {bad, " kind"};
            if (got.token_start  !== want.token_start)  bad = {bad, " start"};
            if (got.token_length !== want.token_length) bad = {bad, " length"};
            if (got.token_line   !== want.token_line)   bad = {bad, " line"};
            if (got.last_of_run  !== want.last_of_run)  bad = {bad, " last"};
            if (bad != "") report({"wrong", bad}, want, got);
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_item  i_item = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_token o_token;

    // Percentages of cycles in which the source holds back and the sink stalls.
    int idle_pct = 0;
    int stall_pct = 0;
    // Raised for a long stretch so that the token queue fills and the input backs up.
    logic hold_active = 1'b0;
    int unsigned cycle_count = 0;

    token_scoreboard board;
    t_item           run_bytes [$];

    proof_language_tokenizer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (o_token)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The sink stalls at random, or throughout a hold-off stretch.
    always @(posedge i_clk) begin
        i_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    // Every output transaction is checked against the oldest predicted token.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_token(o_token);
    end

    // Watchdog: a hang or a lost token ends the run here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("proof_language_tokenizer_unit verification failed");
            $finish;
        end
    end

    // Offers one transaction, with random idle cycles before it, and waits until it is
    // taken. Valid stays high and the payload steady while the block stalls.
    task automatic send(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        board.note_item(it);
    endtask

    task automatic send_byte(int b);
        t_item it;
        it.func        = FUNC_BYTE;
        it.source_byte = 8'(b);
        send(it);
    endtask

    // The byte of an end transaction is meaningless, but it is still varied.
    task automatic send_end(int b);
        t_item it;
        it.func        = FUNC_END;
        it.source_byte = 8'(b);
        send(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic hold_off(int cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active <= 1'b0;
    endtask

    function automatic void put(int b);
        t_item it;
        it.func        = FUNC_BYTE;
        it.source_byte = 8'(b);
        run_bytes = {run_bytes, it};
    endfunction

    function automatic int any_word_char();
        case ($urandom_range(3))
            0:       return CH_LA + $urandom_range(25);
            1:       return CH_UA + $urandom_range(25);
            2:       return CH_ZERO + $urandom_range(9);
            default: return $urandom_range(1) ? CH_UNDER : CH_APOS;
        endcase
    endfunction

    // Appends one lexical fragment: mostly well-formed tokens with random content, now
    // and then broken sequences, raw noise or an end of source. Fragments are often
    // packed together with no blank between them, so that the joins get exercised too.
    function automatic void queue_fragment();
        string  punct;
        t_item  it;
        punct = "()[]{}+*,;:=.!?|&^~@#$%/";
        case ($urandom_range(13))
            0, 1: begin
                put(CH_LA + $urandom_range(25));
                repeat ($urandom_range(4)) put(any_word_char());
            end
            2, 3: begin
                repeat (1 + $urandom_range(3)) put(CH_ZERO + $urandom_range(9));
                if ($urandom_range(2) == 0) begin
                    put($urandom_range(1) ? CH_DOT : CH_SLASH);
                    if ($urandom_range(1))
                        repeat (1 + $urandom_range(2)) put(CH_ZERO + $urandom_range(9));
                end
            end
            4: begin
                put(CH_DASH);
                repeat (1 + $urandom_range(2)) put(CH_ZERO + $urandom_range(9));
            end
            5: begin
                // Strings may hold newlines; now and then one is left open.
                put(CH_QUOTE);
                repeat ($urandom_range(5))
                    put(($urandom_range(5) == 0) ? CH_NL : 8'h20 + $urandom_range(94));
                if ($urandom_range(7) != 0) put(CH_QUOTE);
            end
            6: begin
                put(CH_DASH);
                put(CH_DASH);
                repeat ($urandom_range(5)) put(8'h20 + $urandom_range(94));
                if ($urandom_range(5) != 0) put(CH_NL);
            end
            7: begin
                put(UTF_LEAD);
                put(UTF_MID);
                put($urandom_range(1) ? UTF_MID : UTF_NOTIN);
            end
            8: begin
                put(UTF_LEAD);
                if ($urandom_range(1)) put(UTF_MID);
                put($urandom_range(255));
            end
            9: begin
                put($urandom_range(1) ? CH_LT : CH_GT);
                if ($urandom_range(1)) put(CH_EQ);
            end
            10: begin
                if ($urandom_range(3) == 0) put(8'h80 + $urandom_range(127));
                else put(punct[$urandom_range(punct.len() - 1)]);
            end
            11: begin
                if ($urandom_range(1)) put(CH_TAB + $urandom_range(4));
                else put(CH_SPACE);
            end
            12: repeat (1 + $urandom_range(2)) put($urandom_range(255));
            default: begin
                if ($urandom_range(2) == 0) begin
                    it.func        = FUNC_END;
                    it.source_byte = 8'($urandom_range(255));
                    run_bytes = {run_bytes, it};
                end else begin
                    put(CH_NL);
                end
            end
        endcase
        if ($urandom_range(1)) put($urandom_range(1) ? CH_SPACE : CH_NL);
    endfunction

    // One random phase of about n_items transactions under the given idling.
    // With squeeze set, the sink holds off for a long stretch early in the phase.
    task automatic random_phase(int src_pct, int snk_pct, int n_items, bit squeeze);
        int sent;
        sent      = 0;
        idle_pct  = src_pct;
        stall_pct = snk_pct;
        while (sent < n_items) begin
            if (squeeze && sent >= 8) begin
                fork
                    hold_off(300);
                join_none
                squeeze = 1'b0;
            end
            queue_fragment();
            while (run_bytes.size() > 0) begin
                send(run_bytes.pop_front());
                sent++;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases at full rate. First an end on an empty source.
        send_end(8'h00);
        // Signed number at the start, a closing bracket as a term, then a dash that
        // follows a term and therefore stays a symbol.
        send_text("-5)x-2");
        // Lone separator after a number, then a broken two-byte UTF-8 prefix followed by
        // a null byte: three tokens from one transaction.
        send_text("4/");
        send_byte(UTF_LEAD);
        send_byte(UTF_MID);
        send_byte(8'h00);
        // Broken one-byte prefix.
        send_byte(UTF_LEAD);
        send_text("A");
        // Element-of and not-element-of.
        send_byte(UTF_LEAD);
        send_byte(UTF_MID);
        send_byte(UTF_MID);
        send_byte(UTF_LEAD);
        send_byte(UTF_MID);
        send_byte(UTF_NOTIN);
        // Compare pair, a lone greater-than and the top byte value.
        send_text("<=>");
        send_byte(8'hFF);
        // A comment still open at the end of source emits nothing.
        send_text("\n--z");
        send_end(8'hFF);
        // An unclosed string runs to the end of source.
        send_text("\"q");
        send_end(8'h5A);

        // Random phases: no idling with a long sink hold-off, then source idling,
        // sink stalling, and both together.
        random_phase(0, 0, 40, 1'b1);
        random_phase(62, 0, 40, 1'b0);
        random_phase(0, 62, 40, 1'b0);
        random_phase(24, 24, 40, 1'b0);

        // A short source closed while a string is still open.
        idle_pct  = 0;
        stall_pct = 0;
        send_text("ab \"x");
        send_end($urandom_range(255));
        i_valid <= 1'b0;

        while (board.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_tokens.size() == 0) begin
            $display("proof_language_tokenizer_unit verification clean");
        end else begin
            $display("proof_language_tokenizer_unit verification failed");
        end
        $finish;
    end

endmodule
